// ----- rtl/ws2812_frame_serializer_defines.svh -----
// Assertion macros shared by the serializer RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef WS2812_FRAME_SERIALIZER_DEFINES_SVH
`define WS2812_FRAME_SERIALIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wsfs_pkg.sv -----
// Types, register codes and reset values for the LED frame serializer.
// Depends on nothing; used by the top level, the front end and the back end.
package wsfs_pkg;

    localparam int MAX_PIXELS_DEF = 256;
    localparam int QUEUE_DEPTH    = 2;
    localparam int ROW_DATA_W     = 24;
    localparam int REG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [REG_IDX_W-1:0] REG_PIXEL_COUNT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BIT_PERIOD   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LATCH_GAP    = 3'd4;

    localparam logic [8:0]  RST_PIXEL_COUNT = 9'd256;
    localparam logic [7:0]  RST_ONE_HIGH    = 8'd13;
    localparam logic [7:0]  RST_ZERO_HIGH   = 8'd6;
    localparam logic [7:0]  RST_BIT_PERIOD  = 8'd20;
    localparam logic [15:0] RST_LATCH_GAP   = 16'd800;

    localparam logic [7:0] MIN_PERIOD = 8'd2;
    localparam logic [2:0] BIT_LAST   = 3'd7;
    localparam logic [1:0] LANE_FIRST = 2'd0;
    localparam logic [1:0] LANE_MID   = 2'd1;
    localparam logic [1:0] LANE_LAST  = 2'd2;

    typedef struct packed {
        logic       start_request;
        logic       we_ok;
        logic [7:0] pixel_index;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic sending;
        logic frame_done;
    } result_t;

    typedef struct packed {
        logic [7:0]  one_high_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  bit_period_ticks;
        logic [15:0] latch_gap_ticks;
    } cfg_t;

endpackage

// ----- rtl/ws2812_frame_serializer.sv -----
// Top level of the one-wire LED frame serializer.
// Depends on wsfs_pkg, wsfs_front, wsfs_fifo and wsfs_back.
//
// Each input beat is one tick of the line timing. A beat may write three
// bytes for one pixel (dropped if the index is at or beyond the chain
// length) and may request a frame. Each accepted beat yields exactly one
// result beat: the line level for that tick, a sending flag and a
// frame-done pulse on the last tick of the last bit.
// Input: push/full. Results: empty/pop, oldest result on the ports while
// empty is low. Config: cfg_valid/cfg_ready with cfg_index and cfg_data,
// always ready; write it only while no beat is in flight.
// With both queues empty, a beat is registered in the item queue and then
// its result in the result queue before the result reaches the ports.
// Throughput: the back end retires one tick, so one beat, per cycle unless
// the result queue is full or clearing runs; a two-entry queue is on each side.
// Reset: all state returns to idle and the frame store is zeroed by a pass
// over all MAX_PIXELS rows, one pixel row per cycle, with full held high.
// A stalled receiver fills the result queue, then the item queue, and full
// rises; no beat is lost or dropped.
module ws2812_frame_serializer #(
    parameter int MAX_PIXELS = wsfs_pkg::MAX_PIXELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wsfs_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [wsfs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            write_enable,
    input  logic [7:0]                      pixel_index,
    input  logic [7:0]                      first_byte,
    input  logic [7:0]                      second_byte,
    input  logic [7:0]                      third_byte,
    input  logic                            start_request,
    output logic                            empty,
    input  logic                            pop,
    output logic                            line_level,
    output logic                            sending,
    output logic                            frame_done
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);

    wsfs_pkg::item_t   fe_item, be_item;
    wsfs_pkg::cfg_t    cfg;
    wsfs_pkg::result_t be_res, out_res;
    logic [CNT_W-1:0]  npix;
    logic              fe_push, q_full, q_empty, be_pop;
    logic              res_push, res_full, clearing;

    wsfs_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .write_enable  (write_enable),
        .pixel_index   (pixel_index),
        .first_byte    (first_byte),
        .second_byte   (second_byte),
        .third_byte    (third_byte),
        .start_request (start_request),
        .queue_full    (q_full),
        .clearing      (clearing),
        .item_push     (fe_push),
        .item          (fe_item),
        .cfg           (cfg),
        .npix          (npix)
    );

    wsfs_fifo #(
        .WIDTH ($bits(wsfs_pkg::item_t)),
        .DEPTH (wsfs_pkg::QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .wdata (fe_item),
        .full  (q_full),
        .pop   (be_pop),
        .rdata (be_item),
        .empty (q_empty)
    );

    wsfs_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .npix       (npix),
        .item       (be_item),
        .item_valid (!q_empty),
        .item_pop   (be_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (be_res),
        .clearing   (clearing)
    );

    wsfs_fifo #(
        .WIDTH ($bits(wsfs_pkg::result_t)),
        .DEPTH (wsfs_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (be_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign line_level = out_res.line_level;
    assign sending    = out_res.sending;
    assign frame_done = out_res.frame_done;

endmodule

// ----- rtl/wsfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the frame store.
module wsfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/wsfs_fifo.sv -----
// Small show-ahead queue built from flip-flops.
// Depends on nothing; used between front and back and on the result side.
module wsfs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/wsfs_front.sv -----
// Front end: configuration registers, limit handling and item classification.
// Depends on wsfs_pkg; feeds the item queue and the serializer back end.
module wsfs_front #(
    parameter int MAX_PIXELS = wsfs_pkg::MAX_PIXELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wsfs_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [wsfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 write_enable,
    input  logic [7:0]                           pixel_index,
    input  logic [7:0]                           first_byte,
    input  logic [7:0]                           second_byte,
    input  logic [7:0]                           third_byte,
    input  logic                                 start_request,
    input  logic                                 queue_full,
    input  logic                                 clearing,
    output logic                                 item_push,
    output wsfs_pkg::item_t                      item,
    output wsfs_pkg::cfg_t                       cfg,
    output logic [$clog2(MAX_PIXELS + 1)-1:0]    npix
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    logic [8:0]  pixel_count_reg;
    logic [7:0]  one_high_reg;
    logic [7:0]  zero_high_reg;
    logic [7:0]  bit_period_reg;
    logic [15:0] latch_gap_reg;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= wsfs_pkg::RST_PIXEL_COUNT;
            one_high_reg    <= wsfs_pkg::RST_ONE_HIGH;
            zero_high_reg   <= wsfs_pkg::RST_ZERO_HIGH;
            bit_period_reg  <= wsfs_pkg::RST_BIT_PERIOD;
            latch_gap_reg   <= wsfs_pkg::RST_LATCH_GAP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wsfs_pkg::REG_PIXEL_COUNT: pixel_count_reg <= cfg_data[8:0];
                wsfs_pkg::REG_ONE_HIGH:    one_high_reg    <= cfg_data[7:0];
                wsfs_pkg::REG_ZERO_HIGH:   zero_high_reg   <= cfg_data[7:0];
                wsfs_pkg::REG_BIT_PERIOD:  bit_period_reg  <= cfg_data[7:0];
                wsfs_pkg::REG_LATCH_GAP:   latch_gap_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // clamp pixel count to 1..MAX_PIXELS and bit period to at least two
    always_comb
    begin
        if (pixel_count_reg == '0)
        begin
            npix = CNT_W'(1);
        end
        else if (CMP_W'(pixel_count_reg) > CMP_W'(MAX_PIXELS))
        begin
            npix = CNT_W'(MAX_PIXELS);
        end
        else
        begin
            npix = CNT_W'(pixel_count_reg);
        end
    end

    assign cfg.one_high_ticks   = one_high_reg;
    assign cfg.zero_high_ticks  = zero_high_reg;
    assign cfg.bit_period_ticks = (bit_period_reg < wsfs_pkg::MIN_PERIOD) ?
                                  wsfs_pkg::MIN_PERIOD : bit_period_reg;
    assign cfg.latch_gap_ticks  = latch_gap_reg;

    assign full      = queue_full || clearing;
    assign item_push = push && !full;

    // drop writes beyond the chain length
    assign item.we_ok         = write_enable && (CMP_W'(pixel_index) < CMP_W'(npix));
    assign item.start_request = start_request;
    assign item.pixel_index   = pixel_index;
    assign item.first_byte    = first_byte;
    assign item.second_byte   = second_byte;
    assign item.third_byte    = third_byte;

endmodule

// ----- rtl/wsfs_back.sv -----
// Back end: frame store, clearing pass, start/latch control and bit timing.
// Depends on wsfs_pkg, wsfs_ram and the assertion macro header.
`include "ws2812_frame_serializer_defines.svh"

module wsfs_back #(
    parameter int MAX_PIXELS = wsfs_pkg::MAX_PIXELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wsfs_pkg::cfg_t                    cfg,
    input  logic [$clog2(MAX_PIXELS + 1)-1:0] npix,
    input  wsfs_pkg::item_t                   item,
    input  logic                              item_valid,
    output logic                              item_pop,
    input  logic                              res_full,
    output logic                              res_push,
    output wsfs_pkg::result_t                 res,
    output logic                              clearing
);

    localparam int ROW_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int DW    = wsfs_pkg::ROW_DATA_W;

    logic             clr_active_reg, clr_active_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic             step;

    logic             ram_we;
    logic [ROW_W-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0]    ram_wdata, ram_rdata;
    logic             lw_valid_reg;
    logic [ROW_W-1:0] lw_addr_reg;
    logic [DW-1:0]    lw_data_reg;
    logic [ROW_W-1:0] raddr_reg;
    logic [DW-1:0]    row_data;
    logic [1:0]       load_lane;
    logic [7:0]       load_byte;

    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       lane_reg, lane_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       shift_reg, shift_next;
    logic [15:0]      latch_reg, latch_next;

    logic [7:0]       high_ticks;
    logic [8:0]       tick_inc;
    logic [CNT_W-1:0] row_inc;
    logic             line_v, snd_v, done_v;

    assign step     = item_valid && !res_full && !clr_active_reg;
    assign item_pop = step;
    assign res_push = step;
    assign clearing = clr_active_reg;

    // zero one row per cycle after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg)
        begin
            if (clr_row_reg == ROW_W'(MAX_PIXELS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_row_next = clr_row_reg + ROW_W'(1);
            end
        end
    end

    assign ram_we    = clr_active_reg || (step && item.we_ok);
    assign ram_waddr = clr_active_reg ? clr_row_reg : ROW_W'(item.pixel_index);
    assign ram_wdata = clr_active_reg ? '0 :
                       {item.first_byte, item.second_byte, item.third_byte};

    wsfs_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // forward this beat's write and last cycle's write over the RAM output
    always_comb
    begin
        priority if (ram_we && (ram_waddr == raddr_reg))
        begin
            row_data = ram_wdata;
        end
        else if (lw_valid_reg && (lw_addr_reg == raddr_reg))
        begin
            row_data = lw_data_reg;
        end
        else
        begin
            row_data = ram_rdata;
        end
    end

    always_comb
    begin
        if (!busy_reg || (lane_reg == wsfs_pkg::LANE_LAST))
        begin
            load_lane = wsfs_pkg::LANE_FIRST;
        end
        else
        begin
            load_lane = lane_reg + 2'd1;
        end
        unique case (load_lane)
            wsfs_pkg::LANE_FIRST: load_byte = row_data[DW-1 -: 8];
            wsfs_pkg::LANE_MID:   load_byte = row_data[DW-9 -: 8];
            default:              load_byte = row_data[7:0];
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        pend_next  = pend_reg;
        row_next   = row_reg;
        lane_next  = lane_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        latch_next = latch_reg;
        high_ticks = '0;
        tick_inc   = '0;
        row_inc    = '0;
        line_v     = 1'b0;
        snd_v      = 1'b0;
        done_v     = 1'b0;
        if (step)
        begin
            pend_next = pend_reg || item.start_request;
            if (!busy_reg)
            begin
                if (pend_next && (latch_reg == '0))
                begin
                    pend_next  = 1'b0;
                    busy_next  = 1'b1;
                    row_next   = '0;
                    lane_next  = wsfs_pkg::LANE_FIRST;
                    bit_next   = '0;
                    tick_next  = '0;
                    shift_next = load_byte;
                end
                else if (latch_reg != '0)
                begin
                    latch_next = latch_reg - 16'd1;
                end
            end
            if (busy_next)
            begin
                high_ticks = shift_next[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
                snd_v      = 1'b1;
                line_v     = (tick_next < high_ticks);
                tick_inc   = {1'b0, tick_next} + 9'd1;
                if (tick_inc >= {1'b0, cfg.bit_period_ticks})
                begin
                    tick_next  = '0;
                    shift_next = {shift_next[6:0], 1'b0};
                    if (bit_next == wsfs_pkg::BIT_LAST)
                    begin
                        bit_next = '0;
                        if (lane_next == wsfs_pkg::LANE_LAST)
                        begin
                            row_inc = CNT_W'(row_next) + CNT_W'(1);
                            if (row_inc >= npix)
                            begin
                                busy_next  = 1'b0;
                                row_next   = '0;
                                lane_next  = wsfs_pkg::LANE_FIRST;
                                done_v     = 1'b1;
                                latch_next = cfg.latch_gap_ticks;
                            end
                            else
                            begin
                                row_next   = ROW_W'(row_inc);
                                lane_next  = wsfs_pkg::LANE_FIRST;
                                shift_next = load_byte;
                            end
                        end
                        else if (CNT_W'(row_next) >= npix)
                        begin
                            busy_next  = 1'b0;
                            row_next   = '0;
                            lane_next  = wsfs_pkg::LANE_FIRST;
                            done_v     = 1'b1;
                            latch_next = cfg.latch_gap_ticks;
                        end
                        else
                        begin
                            lane_next  = lane_next + 2'd1;
                            shift_next = load_byte;
                        end
                    end
                    else
                    begin
                        bit_next = bit_next + 3'd1;
                    end
                end
                else
                begin
                    tick_next = tick_inc[7:0];
                end
            end
        end
    end

    // prefetch the row that holds the next byte to load
    always_comb
    begin
        if (!busy_next)
        begin
            ram_raddr = '0;
        end
        else if (lane_next == wsfs_pkg::LANE_LAST)
        begin
            ram_raddr = row_next + ROW_W'(1);
        end
        else
        begin
            ram_raddr = row_next;
        end
    end

    assign res.line_level = line_v;
    assign res.sending    = snd_v;
    assign res.frame_done = done_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            lw_valid_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            row_reg        <= '0;
            lane_reg       <= wsfs_pkg::LANE_FIRST;
            bit_reg        <= '0;
            tick_reg       <= '0;
            shift_reg      <= '0;
            latch_reg      <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_row_reg    <= clr_row_next;
            lw_valid_reg   <= ram_we;
            busy_reg       <= busy_next;
            pend_reg       <= pend_next;
            row_reg        <= row_next;
            lane_reg       <= lane_next;
            bit_reg        <= bit_next;
            tick_reg       <= tick_next;
            shift_reg      <= shift_next;
            latch_reg      <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lw_addr_reg <= ram_waddr;
        lw_data_reg <= ram_wdata;
        raddr_reg   <= ram_raddr;
    end

    `WSFS_ASSERT_HOLDS(a_no_beat_in_clear, clk, rst_n, clr_active_reg, !step,
        "item taken during store clearing")
    `WSFS_ASSERT_HOLDS(a_done_only_busy, clk, rst_n, step && done_v, busy_reg,
        "frame end reported while idle")
    `WSFS_ASSERT_HOLDS(a_lane_range, clk, rst_n, 1'b1, lane_reg <= wsfs_pkg::LANE_LAST,
        "byte lane out of range")
    `WSFS_ASSERT_HOLDS(a_idle_home, clk, rst_n, !busy_reg,
        (row_reg == '0) && (lane_reg == '0) && (bit_reg == '0),
        "position not home while idle")
    `WSFS_ASSERT_NEXT(a_latch_reload, clk, rst_n, step && done_v,
        !busy_reg && (latch_reg == $past(cfg.latch_gap_ticks)),
        "latch gap not reloaded after frame")

endmodule
